[hdl/sha1sh_pkg.sv]
// Shared types, constants and round functions of the SHA-1 stream hasher.
package sha1sh_pkg;

    // Message words in one 64-byte block, and the schedule memory address
    localparam int BLOCK_WORDS = 16;
    typedef logic [3:0] word_addr_t;

    // Round counter boundaries
    localparam logic [6:0] MSG_ROUNDS   = 7'd16;
    localparam logic [6:0] ROUND_PHASE2 = 7'd20;
    localparam logic [6:0] ROUND_PHASE3 = 7'd40;
    localparam logic [6:0] ROUND_PHASE4 = 7'd60;
    localparam logic [6:0] ROUND_COUNT  = 7'd80;

    // Padding: marker byte, byte position where the 64-bit length starts, last byte position
    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [5:0] LAST_POS   = 6'd63;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    // Initial hash values
    localparam logic [31:0] H_INIT [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // Round constants
    localparam logic [31:0] K_PHASE1 = 32'h5A827999;
    localparam logic [31:0] K_PHASE2 = 32'h6ED9EBA1;
    localparam logic [31:0] K_PHASE3 = 32'h8F1BBCDC;
    localparam logic [31:0] K_PHASE4 = 32'hCA62C1D6;

    // Input transaction
    typedef struct packed {
        logic [7:0] message_byte;
        logic       last_byte;
    } msg_t;

    // Output transaction
    typedef struct packed {
        logic [31:0] digest_a;
        logic [31:0] digest_b;
        logic [31:0] digest_c;
        logic [31:0] digest_d;
        logic [31:0] digest_e;
    } digest_t;

    // Write port of the schedule memory
    typedef struct packed {
        logic        en;
        word_addr_t  addr;
        logic [31:0] data;
    } mem_wr_t;

    // Commands from the byte sequencer to the compression engine
    typedef struct packed {
        logic start;
        logic reinit;
    } core_ctrl_t;

    // Round constant for a given round
    function automatic logic [31:0] sha1_k(input logic [6:0] round);
        logic [31:0] k;
        if (round < ROUND_PHASE2)
            k = K_PHASE1;
        else if (round < ROUND_PHASE3)
            k = K_PHASE2;
        else if (round < ROUND_PHASE4)
            k = K_PHASE3;
        else
            k = K_PHASE4;
        return k;
    endfunction

    // Boolean function for a given round
    function automatic logic [31:0] sha1_f(input logic [6:0] round, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (round < ROUND_PHASE2)
            f = (b & c) | (~b & d);
        else if (round < ROUND_PHASE3)
            f = b ^ c ^ d;
        else if (round < ROUND_PHASE4)
            f = (b & c) | (b & d) | (c & d);
        else
            f = b ^ c ^ d;
        return f;
    endfunction

endpackage

[hdl/sha1_stream_hasher.sv]
// Top level of the SHA-1 stream hasher: byte intake, padding sequencer, digest output.
//
//   channel  direction  handshake               payload
//   msg      in         msg_valid / msg_stall   msg_t    (message_byte, last_byte)
//   digest   out        digest_valid / digest_stall  digest_t (digest_a .. digest_e)
//
// Bytes are taken while a block fills. Each full block then holds the byte input off while
// it is compressed: each round runs as phase 0 and phase 1, since the schedule memory gives
// two reads a cycle, then the hash is folded and done is reported. The final byte adds the
// padding bytes, one or two compressions and a hand-over state.
// Reset clears position, bit count and the hash to the initial values; no clearing pass.
// A waiting digest does not block new bytes; a second digest waits until the first is taken.
module sha1_stream_hasher
    import sha1sh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    msg_valid,
    output logic    msg_stall,
    input  msg_t    msg,
    output logic    digest_valid,
    input  logic    digest_stall,
    output digest_t digest
);

    typedef enum logic [1:0] {
        ST_TAKE,
        ST_PAD,
        ST_COMP,
        ST_FINISH
    } state_t;

    state_t      state_reg;
    logic [5:0]  pos_reg;
    logic [63:0] bit_count_reg;
    logic [23:0] word_reg;
    logic        pad_after_reg;
    logic        last_comp_reg;
    logic        marker_done_reg;
    logic        fin_blk_reg;
    logic        out_valid_reg;
    digest_t     out_reg;

    logic        take_fire;
    logic        byte_fire;
    logic [7:0]  pad_byte;
    logic [7:0]  byte_val;
    logic        out_free;
    logic        core_done;
    core_ctrl_t  core_ctrl;
    mem_wr_t     seq_wr;
    mem_wr_t     core_wr;
    mem_wr_t     mem_wr;
    word_addr_t  rd_addr0, rd_addr1;
    logic [31:0] rd_data0, rd_data1;
    digest_t     hash;

    // Accept bytes only while gathering a block
    assign msg_stall = (state_reg != ST_TAKE);
    assign take_fire = (state_reg == ST_TAKE) && msg_valid;
    assign byte_fire = take_fire || (state_reg == ST_PAD);

    // Padding byte: marker, then zero fill, then the big-endian length in the final block
    always_comb
    begin
        if (!marker_done_reg)
            pad_byte = PAD_MARKER;
        else if (fin_blk_reg && (pos_reg >= LEN_POS))
            pad_byte = bit_count_reg[63:56];
        else
            pad_byte = 8'h00;
    end

    assign byte_val = (state_reg == ST_PAD) ? pad_byte : msg.message_byte;

    // Write a word once its fourth byte arrives
    assign seq_wr.en   = byte_fire && (pos_reg[1:0] == 2'b11);
    assign seq_wr.addr = pos_reg[5:2];
    assign seq_wr.data = {word_reg, byte_val};
    assign mem_wr      = core_wr.en ? core_wr : seq_wr;

    assign out_free         = !out_valid_reg || !digest_stall;
    assign core_ctrl.start  = byte_fire && (pos_reg == LAST_POS);
    assign core_ctrl.reinit = (state_reg == ST_FINISH) && out_free;

    // Gather bytes into the high part of the pending word; latch the digest on hand-over
    always_ff @(posedge clk)
    begin
        if (byte_fire)
        begin
            word_reg <= {word_reg[15:0], byte_val};
        end
        if (core_ctrl.reinit)
        begin
            out_reg <= hash;
        end
    end

    // Sequence intake, padding, compression and digest hand-over
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_TAKE;
            pos_reg         <= 6'd0;
            bit_count_reg   <= 64'd0;
            pad_after_reg   <= 1'b0;
            last_comp_reg   <= 1'b0;
            marker_done_reg <= 1'b0;
            fin_blk_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            // Drop the digest once taken, unless a new one replaces it
            if (core_ctrl.reinit)
                out_valid_reg <= 1'b1;
            else if (!digest_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_TAKE:
                begin
                    if (msg_valid)
                    begin
                        pos_reg         <= pos_reg + 6'd1;
                        bit_count_reg   <= bit_count_reg + BITS_PER_BYTE;
                        marker_done_reg <= 1'b0;
                        fin_blk_reg     <= 1'b0;
                        if (pos_reg == LAST_POS)
                        begin
                            state_reg     <= ST_COMP;
                            pad_after_reg <= msg.last_byte;
                            last_comp_reg <= 1'b0;
                        end
                        else if (msg.last_byte)
                        begin
                            state_reg <= ST_PAD;
                        end
                    end
                end

                ST_PAD:
                begin
                    pos_reg <= pos_reg + 6'd1;
                    if (!marker_done_reg)
                    begin
                        marker_done_reg <= 1'b1;
                    end
                    else if (fin_blk_reg && (pos_reg >= LEN_POS))
                    begin
                        bit_count_reg <= {bit_count_reg[55:0], 8'h00};
                    end

                    if (pos_reg == LAST_POS)
                    begin
                        // Block full: compress; the length goes in the next block if not here
                        state_reg     <= ST_COMP;
                        last_comp_reg <= fin_blk_reg;
                        pad_after_reg <= !fin_blk_reg;
                        fin_blk_reg   <= 1'b1;
                    end
                    else if (!marker_done_reg && (pos_reg < LEN_POS))
                    begin
                        fin_blk_reg <= 1'b1;
                    end
                end

                ST_COMP:
                begin
                    if (core_done)
                    begin
                        if (last_comp_reg)
                            state_reg <= ST_FINISH;
                        else if (pad_after_reg)
                            state_reg <= ST_PAD;
                        else
                            state_reg <= ST_TAKE;
                    end
                end

                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_TAKE;
                    end
                end

                default:
                begin
                    state_reg <= ST_TAKE;
                end
            endcase
        end
    end

    assign digest_valid = out_valid_reg;
    assign digest       = out_reg;

    sha1sh_wmem u_wmem (
        .clk      (clk),
        .wr       (mem_wr),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1)
    );

    sha1sh_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (core_ctrl),
        .done     (core_done),
        .rd_addr0 (rd_addr0),
        .rd_addr1 (rd_addr1),
        .rd_data0 (rd_data0),
        .rd_data1 (rd_data1),
        .wr       (core_wr),
        .hash     (hash)
    );

endmodule

[hdl/sha1sh_wmem.sv]
// Message schedule memory: 16 words, one write port, two registered read ports.
module sha1sh_wmem
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  mem_wr_t     wr,
    input  word_addr_t  rd_addr0,
    input  word_addr_t  rd_addr1,
    output logic [31:0] rd_data0,
    output logic [31:0] rd_data1
);

    logic [31:0] mem [BLOCK_WORDS];

    // Write one word, read two through registered outputs
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data0 <= mem[rd_addr0];
        rd_data1 <= mem[rd_addr1];
    end

endmodule

[hdl/sha1sh_core.sv]
// SHA-1 compression engine: rounds alternate phase 0 and phase 1, schedule kept in place in the memory.
module sha1sh_core
    import sha1sh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctrl_t  ctrl,
    output logic        done,
    output word_addr_t  rd_addr0,
    output word_addr_t  rd_addr1,
    input  logic [31:0] rd_data0,
    input  logic [31:0] rd_data1,
    output mem_wr_t     wr,
    output digest_t     hash
);

    logic        run_reg;
    logic        phase_reg;
    logic [6:0]  round_reg;
    logic        fin_reg;
    logic        done_reg;
    logic [31:0] h_reg [5];

    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] ek_reg;
    logic [31:0] xor_reg;

    logic [6:0]  calc_round;
    logic        calc_en;
    logic [31:0] w_mix;
    logic [31:0] w_now;
    logic [31:0] t_next;

    // Round finished in phase 0 is the one whose words were read in the previous pair
    assign calc_round = round_reg - 7'd1;
    assign calc_en    = run_reg && !phase_reg && (round_reg != 7'd0);

    // Phase 0 reads w[r-3] and w[r-8]; phase 1 reads w[r-14] and w[r-16] (or w[r])
    always_comb
    begin
        if (!phase_reg)
        begin
            rd_addr0 = round_reg[3:0] + 4'd13;
            rd_addr1 = round_reg[3:0] + 4'd8;
        end
        else
        begin
            rd_addr0 = round_reg[3:0] + 4'd2;
            rd_addr1 = round_reg[3:0];
        end
    end

    // Expand the schedule word, or take the message word directly in the first rounds
    assign w_mix = xor_reg ^ rd_data0 ^ rd_data1;
    assign w_now = (calc_round < MSG_ROUNDS) ? rd_data1 : {w_mix[30:0], w_mix[31]};

    assign t_next = {a_reg[26:0], a_reg[31:27]} + sha1_f(calc_round, b_reg, c_reg, d_reg)
                  + ek_reg + w_now;

    // Write the expanded word back over w[r-16]
    assign wr.en   = calc_en && (calc_round >= MSG_ROUNDS);
    assign wr.addr = calc_round[3:0];
    assign wr.data = w_now;

    // Sequence rounds, fold the working variables into the hash, reload the initial hash on reinit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            phase_reg <= 1'b0;
            round_reg <= 7'd0;
            fin_reg   <= 1'b0;
            done_reg  <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            done_reg <= fin_reg;
            fin_reg  <= 1'b0;
            if (ctrl.start)
            begin
                run_reg   <= 1'b1;
                phase_reg <= 1'b0;
                round_reg <= 7'd0;
            end
            else if (run_reg)
            begin
                if (!phase_reg)
                begin
                    if (round_reg == ROUND_COUNT)
                    begin
                        run_reg <= 1'b0;
                        fin_reg <= 1'b1;
                    end
                    else
                    begin
                        phase_reg <= 1'b1;
                    end
                end
                else
                begin
                    phase_reg <= 1'b0;
                    round_reg <= round_reg + 7'd1;
                end
            end

            if (fin_reg)
            begin
                h_reg[0] <= h_reg[0] + a_reg;
                h_reg[1] <= h_reg[1] + b_reg;
                h_reg[2] <= h_reg[2] + c_reg;
                h_reg[3] <= h_reg[3] + d_reg;
                h_reg[4] <= h_reg[4] + e_reg;
            end
            else if (ctrl.reinit)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    // Working variables and per-round partial sums
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= h_reg[0];
            b_reg <= h_reg[1];
            c_reg <= h_reg[2];
            d_reg <= h_reg[3];
            e_reg <= h_reg[4];
        end
        else if (calc_en)
        begin
            a_reg <= t_next;
            b_reg <= a_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            d_reg <= c_reg;
            e_reg <= d_reg;
        end

        // Phase 1: hold first half of the schedule mix and pre-add e and K
        if (run_reg && phase_reg)
        begin
            xor_reg <= rd_data0 ^ rd_data1;
            ek_reg  <= e_reg + sha1_k(round_reg);
        end
    end

    assign done        = done_reg;
    assign hash.digest_a = h_reg[0];
    assign hash.digest_b = h_reg[1];
    assign hash.digest_c = h_reg[2];
    assign hash.digest_d = h_reg[3];
    assign hash.digest_e = h_reg[4];

endmodule
